FILE: rtl/rle_window_sum_unit_assert.svh
// Assertion macros shared by the run-length window sum RTL.
// Every check is clocked on clock and disabled while reset is high.
`ifndef RLE_WINDOW_SUM_UNIT_ASSERT_SVH
`define RLE_WINDOW_SUM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RWS_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define RWS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/rws_pkg.sv
`default_nettype none

package rws_pkg;

   localparam int K_W        = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int VALUE_W    = 32;
   localparam int LEN_W      = 31;
   // Exact window total: up to 31 terms of 32 bits, signed.
   localparam int TOTAL_W    = 37;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_K  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NA_REMOVE = 2'd1;

   localparam logic signed [TOTAL_W-1:0] SUM_LIMIT = 37'sd2147483647;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PUSH_RD,
      ST_PUSH_UPD,
      ST_FORM,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic push_rd;
      logic push_upd;
      logic out_load;
      logic step_inc;
   } cmd_type;

   typedef struct packed {
      logic more_steps;
      logic window_full;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/rle_window_sum_unit.sv
// With the window already full, the first result of a run is presented after the run has
// passed the decide, ring read, total update and form states. A new run is accepted only
// once the current run is done, and a stalled result holds the block until it is taken;
// each element goes through a ring read, a total update and a result check.
// Reset (synchronous, active high) sets k to 1, NA removal off, and empties the window.
// The history ring needs no clearing pass: only slots written since the last clear are used.
`default_nettype none

module rle_window_sum_unit #(
   parameter int MAX_WINDOW = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Configuration write port.
   input  wire                                  csr_we,
   input  wire  [rws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [rws_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // Input runs.
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  signed [rws_pkg::VALUE_W-1:0]   req_run_value,
   input  wire                                  req_run_is_na,
   input  wire  [rws_pkg::LEN_W-1:0]            req_run_length,
   // Result runs.
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [rws_pkg::VALUE_W-1:0]   rsp_sum_value,
   output logic                                 rsp_sum_is_na,
   output logic                                 rsp_overflowed,
   output logic [rws_pkg::LEN_W-1:0]            rsp_out_length,
   output logic                                 rsp_last_of_item
);

   `include "rle_window_sum_unit_assert.svh"

   // The controller sequences each run one element at a time: it reads the
   // element leaving the window, updates the running total and NA count, and
   // then, once the window is full, holds a result until the downstream side takes the transaction.
   // The datapath keeps the ring, the window state and the result registers.
   rws_pkg::cmd_type    cmd;
   rws_pkg::status_type status;

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rws_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_run_value    (req_run_value),
      .req_run_is_na    (req_run_is_na),
      .req_run_length   (req_run_length),
      .cmd              (cmd),
      .status           (status),
      .rsp_sum_value    (rsp_sum_value),
      .rsp_sum_is_na    (rsp_sum_is_na),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_out_length   (rsp_out_length),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // No new run is taken while a result is still pending.
   `RWS_ASSERT_IMPL(a_no_req_during_rsp, rsp_valid, req_stall, "run accepted while result pending")
   // In the cycle after a run is accepted, the block is busy.
   `RWS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "not busy after run accept")
   // A result that is not the last of its run is followed by more work on that run.
   `RWS_ASSERT_NEXT(a_more_after_mid, rsp_valid && !rsp_stall && !rsp_last_of_item, ##1 req_stall,
      "run ended before its last result")

endmodule

`default_nettype wire

FILE: rtl/rws_ctrl.sv
`default_nettype none

module rws_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  rws_pkg::status_type  status,
   output rws_pkg::cmd_type     cmd
);

   rws_pkg::state_type state_ff;
   rws_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rws_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rws_pkg::ST_DECIDE;
            end
         end
         rws_pkg::ST_DECIDE: begin
            if (status.more_steps) begin
               state_in = rws_pkg::ST_PUSH_RD;
            end else begin
               state_in = rws_pkg::ST_IDLE;
            end
         end
         rws_pkg::ST_PUSH_RD: begin
            cmd.push_rd = 1'b1;
            state_in    = rws_pkg::ST_PUSH_UPD;
         end
         rws_pkg::ST_PUSH_UPD: begin
            cmd.push_upd = 1'b1;
            state_in     = rws_pkg::ST_FORM;
         end
         rws_pkg::ST_FORM: begin
            // A window that is not yet full gives no result.
            if (status.window_full) begin
               cmd.out_load = 1'b1;
               state_in     = rws_pkg::ST_RESP;
            end else begin
               cmd.step_inc = 1'b1;
               state_in     = rws_pkg::ST_DECIDE;
            end
         end
         rws_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.step_inc = 1'b1;
               state_in     = rws_pkg::ST_DECIDE;
            end
         end
         default: begin
            state_in = rws_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/rws_dp.sv
`default_nettype none

module rws_dp #(
   parameter int MAX_WINDOW = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_we,
   input  wire  [rws_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire  [rws_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire  signed [rws_pkg::VALUE_W-1:0]     req_run_value,
   input  wire                                    req_run_is_na,
   input  wire  [rws_pkg::LEN_W-1:0]              req_run_length,
   input  rws_pkg::cmd_type                       cmd,
   output rws_pkg::status_type                    status,
   output logic signed [rws_pkg::VALUE_W-1:0]     rsp_sum_value,
   output logic                                   rsp_sum_is_na,
   output logic                                   rsp_overflowed,
   output logic [rws_pkg::LEN_W-1:0]              rsp_out_length,
   output logic                                   rsp_last_of_item
);

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int K_W   = rws_pkg::K_W;
   localparam int TW    = rws_pkg::TOTAL_W;
   localparam int VW    = rws_pkg::VALUE_W;
   localparam int LW    = rws_pkg::LEN_W;

   // Configuration.
   logic [K_W-1:0] cfg_k_ff;
   logic           na_remove_ff;

   // Current run.
   logic signed [VW-1:0] run_value_ff;
   logic                 run_na_ff;
   logic [LW-1:0]        run_len_ff;
   // One spare bit, so the count can step past the widest window.
   logic [K_W:0]         step_cnt_ff;

   // Stream state.
   logic [PTR_W-1:0]     ptr_ff;
   logic [K_W-1:0]       seen_ff;
   logic signed [TW-1:0] total_ff;
   logic [K_W-1:0]       na_cnt_ff;

   // History ring: {na, value}.
   logic [VW:0]          ring_mem [MAX_WINDOW];
   logic [VW:0]          old_ff;

   logic [K_W-1:0]       keff;
   logic [K_W-1:0]       pushes;
   logic [PTR_W:0]       old_sum;
   logic [PTR_W-1:0]     old_addr;
   logic [PTR_W-1:0]     ptr_next;
   logic signed [TW-1:0] sub_term;
   logic signed [TW-1:0] add_term;
   logic                 window_full;

   always_comb begin
      if (cfg_k_ff == '0) begin
         keff = K_W'(1);
      end else if (32'(cfg_k_ff) > MAX_WINDOW) begin
         keff = K_W'(MAX_WINDOW);
      end else begin
         keff = cfg_k_ff;
      end
   end

   // A run pushes min(length, k) elements into the ring.
   assign pushes = (run_len_ff >= LW'(keff)) ? keff : run_len_ff[K_W-1:0];

   always_comb begin
      old_sum = {1'b0, ptr_ff} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(keff);
      if (old_sum >= (PTR_W+1)'(MAX_WINDOW)) begin
         old_sum = old_sum - (PTR_W+1)'(MAX_WINDOW);
      end
      old_addr = old_sum[PTR_W-1:0];
   end

   assign ptr_next    = (32'(ptr_ff) == MAX_WINDOW - 1) ? '0 : ptr_ff + PTR_W'(1);
   assign window_full = (seen_ff >= keff);

   assign status.more_steps  = (step_cnt_ff < {1'b0, pushes});
   assign status.window_full = window_full;

   // The ring is read before it is written, so the oldest slot is
   // still seen when it is also the slot being replaced.
   always_ff @(posedge clock) begin
      if (cmd.push_rd) begin
         old_ff                <= ring_mem[old_addr];
         ring_mem[ptr_ff]      <= {run_na_ff, run_value_ff};
      end
   end

   always_comb begin
      sub_term = '0;
      add_term = '0;
      if (window_full && !old_ff[VW]) begin
         sub_term = TW'(signed'(old_ff[VW-1:0]));
      end
      if (!run_na_ff) begin
         add_term = TW'(run_value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_k_ff     <= K_W'(1);
         na_remove_ff <= 1'b0;
         ptr_ff       <= '0;
         seen_ff      <= '0;
         total_ff     <= '0;
         na_cnt_ff    <= '0;
         step_cnt_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               rws_pkg::CSR_WINDOW_K: begin
                  cfg_k_ff  <= csr_wdata;
                  ptr_ff    <= '0;
                  seen_ff   <= '0;
                  total_ff  <= '0;
                  na_cnt_ff <= '0;
               end
               rws_pkg::CSR_NA_REMOVE: begin
                  na_remove_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            step_cnt_ff <= '0;
         end else if (cmd.step_inc) begin
            step_cnt_ff <= step_cnt_ff + (K_W+1)'(1);
         end
         if (cmd.push_rd) begin
            ptr_ff <= ptr_next;
         end
         if (cmd.push_upd) begin
            total_ff <= total_ff - sub_term + add_term;
            if (!window_full) begin
               seen_ff <= seen_ff + K_W'(1);
            end
            if (window_full && old_ff[VW] && !run_na_ff) begin
               na_cnt_ff <= na_cnt_ff - K_W'(1);
            end else if (!(window_full && old_ff[VW]) && run_na_ff) begin
               na_cnt_ff <= na_cnt_ff + K_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         run_value_ff <= req_run_value;
         run_na_ff    <= req_run_is_na;
         run_len_ff   <= req_run_length;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sum_value  <= '0;
         rsp_sum_is_na  <= 1'b0;
         rsp_overflowed <= 1'b0;
         if (na_cnt_ff != '0 && !na_remove_ff) begin
            rsp_sum_is_na <= 1'b1;
         end else if (total_ff > rws_pkg::SUM_LIMIT || total_ff < -rws_pkg::SUM_LIMIT) begin
            rsp_sum_is_na  <= 1'b1;
            rsp_overflowed <= 1'b1;
         end else begin
            rsp_sum_value <= total_ff[VW-1:0];
         end
         // The k-th push of a long run stands for all its remaining windows.
         if (step_cnt_ff == {1'b0, keff - K_W'(1)}) begin
            rsp_out_length <= run_len_ff - LW'(keff) + LW'(1);
         end else begin
            rsp_out_length <= LW'(1);
         end
         rsp_last_of_item <= ((step_cnt_ff + (K_W+1)'(1)) == {1'b0, pushes});
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Testbench for the run-length window sum unit.
// Runs go in on the req_ channel, window sums come back as runs on the rsp_ channel.
// A predictor in this module keeps its own history ring and window totals, and every
// accepted request transaction queues the result runs it must produce. A separate
// process pops one expectation per accepted response transaction and compares every
// field. Directed tests come first, then phases of random runs under many window
// settings, with random idle bursts on both channels in most phases but the final one.
module testbench;
   import rws_pkg::*;

   localparam int MAX_WIN = 16;
   // How long a run can keep the block busy without producing any result, with a
   // full window's worth of elements each passing the ring read and total update.
   localparam int SETTLE_CYCLES = 80;
   // An index with no register behind it; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [VALUE_W-1:0] sum_value;
      logic                      sum_is_na;
      logic                      overflowed;
      logic [LEN_W-1:0]          out_length;
      logic                      last_of_item;
   } sum_run_type;

   // Clock, reset and all block inputs start at known values.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [VALUE_W-1:0]  req_run_value = '0;
   logic                       req_run_is_na = 1'b0;
   logic [LEN_W-1:0]           req_run_length = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_sum_value;
   logic                       rsp_sum_is_na;
   logic                       rsp_overflowed;
   logic [LEN_W-1:0]           rsp_out_length;
   logic                       rsp_last_of_item;

   // Idle bursts are allowed while this is set; the last phase clears it.
   logic                       idle_on = 1'b1;
   int                         error_count = 0;

   // Predictor state: configuration as written and the sliding window contents.
   logic [CSR_DATA_W-1:0]      cfg_window_k = 5'd1;
   logic                       cfg_na_remove = 1'b0;
   longint                     ring_value[MAX_WIN];
   bit                         ring_na[MAX_WIN];
   int unsigned                ring_wr_ptr;
   int unsigned                fill_count;
   longint                     running_total;
   int unsigned                na_in_window;

   // Result runs still owed by the block, oldest first.
   sum_run_type                expected_sums[$];

   rle_window_sum_unit #(
      .MAX_WINDOW (MAX_WIN)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_run_value    (req_run_value),
      .req_run_is_na    (req_run_is_na),
      .req_run_length   (req_run_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sum_value    (rsp_sum_value),
      .rsp_sum_is_na    (rsp_sum_is_na),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_out_length   (rsp_out_length),
      .rsp_last_of_item (rsp_last_of_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // The window width actually used: zero behaves as one, and anything above the
   // ring depth is clamped to it.
   function automatic int unsigned active_window();
      if (cfg_window_k == '0)
         return 1;
      if (cfg_window_k > MAX_WIN)
         return MAX_WIN;
      return cfg_window_k;
   endfunction

   function automatic void clear_window();
      foreach (ring_value[i]) begin
         ring_value[i] = 0;
         ring_na[i] = 1'b0;
      end
      ring_wr_ptr = 0;
      fill_count = 0;
      running_total = 0;
      na_in_window = 0;
   endfunction

   // Adds one element to the window. Once the window is full, the element k slots
   // back drops out of the total or out of the NA count.
   function automatic void shift_in(logic signed [VALUE_W-1:0] value, logic is_na,
                                    int unsigned k);
      int unsigned oldest;
      if (fill_count >= k) begin
         oldest = (ring_wr_ptr + MAX_WIN - k) % MAX_WIN;
         if (ring_na[oldest])
            na_in_window--;
         else
            running_total -= ring_value[oldest];
      end else begin
         fill_count++;
      end
      ring_value[ring_wr_ptr] = longint'(value);
      ring_na[ring_wr_ptr] = is_na;
      if (is_na)
         na_in_window++;
      else
         running_total += longint'(value);
      ring_wr_ptr = (ring_wr_ptr + 1) % MAX_WIN;
   endfunction

   // Turns the current window into one result run. Unless NA removal is on, an NA element
   // wins over the range check; an exact total outside the symmetric 32-bit range reads as NA
   // with the overflow flag.
   function automatic sum_run_type form_result(logic [LEN_W-1:0] len);
      sum_run_type r;
      r.sum_value = '0;
      r.sum_is_na = 1'b0;
      r.overflowed = 1'b0;
      r.out_length = len;
      r.last_of_item = 1'b0;
      if (na_in_window != 0 && !cfg_na_remove) begin
         r.sum_is_na = 1'b1;
      end else if (running_total > longint'(SUM_LIMIT) ||
                   running_total < -longint'(SUM_LIMIT)) begin
         r.sum_is_na = 1'b1;
         r.overflowed = 1'b1;
      end else begin
         r.sum_value = running_total[VALUE_W-1:0];
      end
      return r;
   endfunction

   // Queues the results of one accepted run: single-length results for the full windows
   // ending in its first k-1 positions, then one long result if the run fills a window.
   function automatic void predict_window_run(logic signed [VALUE_W-1:0] value,
                                              logic is_na, logic [LEN_W-1:0] length);
      int unsigned     k;
      longint unsigned singles;
      sum_run_type     batch[$];
      sum_run_type     r;
      k = active_window();
      if (length == '0)
         return;
      singles = (length < k - 1) ? length : k - 1;
      for (longint unsigned i = 0; i < singles; i++) begin
         shift_in(value, is_na, k);
         if (fill_count >= k)
            batch.push_back(form_result(LEN_W'(1)));
      end
      if (length >= k) begin
         shift_in(value, is_na, k);
         batch.push_back(form_result(LEN_W'(length - k + 1)));
      end
      if (batch.size() > 0) begin
         r = batch.pop_back();
         r.last_of_item = 1'b1;
         batch.push_back(r);
      end
      foreach (batch[i])
         expected_sums.push_back(batch[i]);
   endfunction

   // ---------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------

   // Writes one register, then lowers the enable before returning, so that back-to-back
   // writes never assign the enable twice in one step.
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_WINDOW_K) begin
         cfg_window_k = data;
         clear_window();
      end else if (index == CSR_NA_REMOVE) begin
         cfg_na_remove = data[0];
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one run and returns at the edge where the transaction is accepted. Valid
   // stays high on return so that a following run goes out without a bubble.
   task automatic send_run(logic signed [VALUE_W-1:0] value, logic is_na,
                           logic [LEN_W-1:0] length);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_run_value <= value;
      req_run_is_na <= is_na;
      req_run_length <= length;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_window_run(value, is_na, length);
   endtask

   // Brings the block to rest: every owed result has come back and a run that gives
   // no result has had time to finish.
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The result side stalls in bursts of random length, with quiet stretches
   // in between, while idling is allowed.
   always @(posedge clock) begin : stall_gen
      int unsigned stall_left;
      if (!idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 10);
      end
   end

   // ---------------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------------

   task automatic compare_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Signals are read at the edge itself, so they hold the values that decided the
   // handshake at that edge.
   always @(posedge clock) begin : result_check
      sum_run_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual sum %0d na %0b len %0d",
                     $time, rsp_sum_value, rsp_sum_is_na, rsp_out_length);
            error_count++;
         end else begin
            want = expected_sums.pop_front();
            compare_field("sum_value", want.sum_value, rsp_sum_value);
            compare_field("sum_is_na", want.sum_is_na, rsp_sum_is_na);
            compare_field("overflowed", want.overflowed, rsp_overflowed);
            compare_field("out_length", want.out_length, rsp_out_length);
            compare_field("last_of_item", want.last_of_item, rsp_last_of_item);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Random content
   // ---------------------------------------------------------------------------------

   // Small values whose sums stay in range, values up to 28 bits in magnitude, full-range
   // values, the extremes, and values close to the overflow boundary for the given width.
   function automatic logic signed [VALUE_W-1:0] random_value(int unsigned k);
      int unsigned mag;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
         4, 5: return VALUE_W'($urandom);
         6: begin
            case ($urandom_range(0, 5))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh8000_0001;
               3: return 32'sd0;
               4: return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         7, 8: begin
            mag = $urandom_range(0, 32'h0FFF_FFFF);
            return $urandom_range(0, 1) ? VALUE_W'(mag) : -VALUE_W'(mag);
         end
         default: begin
            mag = 32'h7FFF_FFFF / k + $urandom_range(0, 2);
            return $urandom_range(0, 1) ? VALUE_W'(mag) : -VALUE_W'(mag);
         end
      endcase
   endfunction

   // Mostly lengths around the window width, some zero, some very short and some
   // over the whole 31-bit range. Beyond the window width, the length does not affect how long a run takes.
   function automatic logic [LEN_W-1:0] random_length(int unsigned k);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEN_W'($urandom);
         2: return LEN_W'($urandom_range(1, 3));
         default: return LEN_W'($urandom_range(1, 2 * k + 3));
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Out of reset the window is one element wide and NA propagates.
   task automatic test_reset_defaults();
      send_run(32'sd5, 1'b0, 31'd1);
      send_run(-32'sd7, 1'b0, 31'd100);
      send_run(32'sd0, 1'b1, 31'd3);
   endtask

   // No result comes until k elements are in; a zero-length run changes nothing.
   task automatic test_window_warmup();
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd4);
      write_csr(CSR_NA_REMOVE, 5'd0);
      send_run(32'sd10, 1'b0, 31'd2);
      send_run(32'sd3, 1'b0, 31'd0);
      send_run(32'sd1, 1'b0, 31'd1);
      send_run(32'sd2, 1'b0, 31'd6);
      send_run(-32'sd5, 1'b0, 31'd3);
   endtask

   // NA propagates through the window, then counts as zero once NA removal is on.
   // Changing NA removal keeps the stream state.
   task automatic test_na_rules();
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd3);
      send_run(32'sd4, 1'b0, 31'd3);
      send_run(32'sd0, 1'b1, 31'd2);
      send_run(32'sd6, 1'b0, 31'd4);
      settle_idle();
      write_csr(CSR_NA_REMOVE, 5'd1);
      send_run(32'sd7, 1'b0, 31'd2);
      send_run(32'sd1, 1'b1, 31'd5);
   endtask

   // Exact totals just past the range give NA with the overflow flag; the most
   // negative input is an ordinary value that overflows a window of one.
   task automatic test_overflow();
      settle_idle();
      write_csr(CSR_NA_REMOVE, 5'd0);
      write_csr(CSR_WINDOW_K, 5'd16);
      send_run(32'sh7FFF_FFFF, 1'b0, 31'd16);
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd2);
      send_run(32'sh7FFF_FFFF, 1'b0, 31'd1);
      send_run(32'sd1, 1'b0, 31'd1);
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd1);
      send_run(32'sh8000_0000, 1'b0, 31'd1);
      send_run(32'sh8000_0001, 1'b0, 31'h7FFF_FFFF);
   endtask

   // Width zero acts as one and widths above the ring depth are clamped. A write to
   // an index with no register must leave the window untouched.
   task automatic test_window_range();
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd0);
      send_run(32'sd9, 1'b0, 31'd5);
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd17);
      send_run(32'sd1, 1'b0, 31'd40);
      settle_idle();
      write_csr(CSR_WINDOW_K, 5'd31);
      write_csr(CSR_NA_REMOVE, 5'd1);
      send_run(-32'sd3, 1'b1, 31'd20);
      settle_idle();
      write_csr(CSR_SPARE, 5'h1F);
      send_run(32'sd2, 1'b0, 31'd3);
   endtask

   // Phases of random runs, each under its own window width and NA setting. Some
   // phases change NA removal halfway through. The final phase runs without idling.
   task automatic test_random_runs();
      int          k_plan[10] = '{1, 2, 3, 4, 7, 16, 0, 17, 31, 5};
      int unsigned k;
      for (int phase = 0; phase < 10; phase++) begin
         settle_idle();
         if (phase == 9)
            idle_on <= 1'b0;
         else
            idle_on <= ($urandom_range(0, 4) != 0);
         if (phase == 9)
            k_plan[phase] = $urandom_range(0, 31);
         write_csr(CSR_WINDOW_K, CSR_DATA_W'(k_plan[phase]));
         write_csr(CSR_NA_REMOVE, CSR_DATA_W'($urandom_range(0, 31)));
         k = active_window();
         for (int n = 0; n < 20; n++) begin
            if (n == 10 && $urandom_range(0, 1) == 1) begin
               settle_idle();
               write_csr(CSR_NA_REMOVE, CSR_DATA_W'($urandom_range(0, 31)));
            end
            send_run(random_value(k), ($urandom_range(0, 6) == 0), random_length(k));
         end
      end
   endtask

   initial begin
      clear_window();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_warmup();
      test_na_rules();
      test_overflow();
      test_window_range();
      test_random_runs();
      // Wait for every owed result, then give the block time to show a stray one.
      settle_idle();
      if (error_count == 0)
         $display("** rle_window_sum_unit: PASSED **");
      else
         $display("** rle_window_sum_unit: FAILED **");
      $finish;
   end

   // A hang anywhere, including results that never come, ends the run here.
   initial begin
      #5_000_000;
      $display("** rle_window_sum_unit: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/rws_pkg.sv
rtl/rws_ctrl.sv
rtl/rws_dp.sv
rtl/rle_window_sum_unit.sv
tb/sv/testbench.sv
